// File: hdl/pmu_pkg.sv
`default_nettype none
package pmu_pkg;
    // fixed point format of every word
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    // coefficient (time step or unit component), product and wide square widths
    localparam int COEF_BITS = FRAC_BITS + 2;
    localparam int PROD_BITS = WORD_BITS + 1;
    localparam int SQ_BITS   = 2 * WORD_BITS;
    localparam int DT_BITS   = 16;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef t_word t_wvec [0:2];
    typedef t_coef t_cvec [0:2];
    typedef logic [2:0] t_cfg_idx;

    localparam t_word ONE_Q = t_word'(1 << FRAC_BITS);
    localparam logic [WORD_BITS-2:0] LIFETIME_RESET = 31'd65536;

    // register map
    localparam t_cfg_idx CFG_LIFETIME   = 3'd0;
    localparam t_cfg_idx CFG_STOP_DAMP  = 3'd1;
    localparam t_cfg_idx CFG_ATTR_EN    = 3'd2;
    localparam t_cfg_idx CFG_ATTR_STR   = 3'd3;
    localparam t_cfg_idx CFG_COLOR_R    = 3'd4;
    localparam t_cfg_idx CFG_COLOR_G    = 3'd5;
    localparam t_cfg_idx CFG_COLOR_B    = 3'd6;
    localparam t_cfg_idx CFG_SIZE_DELTA = 3'd7;

    // word modes
    localparam logic MODE_SPAWN = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // x + y or x - y, saturated to the signed word range
    function automatic t_word sat_sum(input t_word x, input t_prod y, input logic sub);
        logic signed [WORD_BITS+1:0] s;
        logic signed [WORD_BITS+1:0] wmax;
        logic signed [WORD_BITS+1:0] wmin;
        wmax = {3'b000, {(WORD_BITS-1){1'b1}}};
        wmin = {3'b111, {(WORD_BITS-1){1'b0}}};
        if (sub) begin
            s = $signed({{2{x[WORD_BITS-1]}}, x}) - $signed({y[PROD_BITS-1], y});
        end else begin
            s = $signed({{2{x[WORD_BITS-1]}}, x}) + $signed({y[PROD_BITS-1], y});
        end
        if (s > wmax) begin
            return wmax[WORD_BITS-1:0];
        end else if (s < wmin) begin
            return wmin[WORD_BITS-1:0];
        end
        return s[WORD_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// File: hdl/pmu_in_if.sv
`default_nettype none
interface pmu_in_if;
    import pmu_pkg::*;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [DT_BITS-1:0] time_delta;
    t_word       vec_x;
    t_word       vec_y;
    t_word       vec_z;
    t_word       init_vel_x;
    t_word       init_vel_y;
    t_word       init_vel_z;

    modport source (output valid, mode, time_delta, vec_x, vec_y, vec_z,
                    init_vel_x, init_vel_y, init_vel_z, input ready);
    modport sink (input valid, mode, time_delta, vec_x, vec_y, vec_z,
                  init_vel_x, init_vel_y, init_vel_z, output ready);
endinterface
`default_nettype wire

// File: hdl/pmu_out_if.sv
`default_nettype none
interface pmu_out_if;
    import pmu_pkg::*;
    logic  valid;
    logic  ready;
    logic  alive;
    t_word pos_x;
    t_word pos_y;
    t_word pos_z;
    t_word red;
    t_word green;
    t_word blue;
    t_word particle_size;

    modport source (output valid, alive, pos_x, pos_y, pos_z, red, green, blue,
                    particle_size, input ready);
    modport sink (input valid, alive, pos_x, pos_y, pos_z, red, green, blue,
                  particle_size, output ready);
endinterface
`default_nettype wire

// File: hdl/pmu_mul.sv
`default_nettype none
module pmu_mul (
    input  logic           i_clk,
    input  logic           i_en,
    input  pmu_pkg::t_word i_a,
    input  pmu_pkg::t_coef i_b,
    output pmu_pkg::t_prod o_prod
);
    import pmu_pkg::*;

    logic [WORD_BITS-1:0]           mag_a;
    logic [COEF_BITS-1:0]           mag_b_full;
    logic [COEF_BITS-2:0]           mag_b;
    logic [WORD_BITS+COEF_BITS-2:0] full;
    logic [WORD_BITS-1:0]           mag_r;
    logic                           neg;
    t_prod                          n_prod;
    t_prod                          r_prod;

    // sign-magnitude multiply, truncated toward zero by dropping fraction bits
    always_comb begin
        mag_a      = i_a[WORD_BITS-1] ? (~i_a + 1'b1) : i_a;
        mag_b_full = i_b[COEF_BITS-1] ? (~i_b + 1'b1) : i_b;
        mag_b      = mag_b_full[COEF_BITS-2:0];
        full       = mag_a * mag_b;
        mag_r      = full[FRAC_BITS +: WORD_BITS];
        neg        = i_a[WORD_BITS-1] ^ i_b[COEF_BITS-1];
        n_prod     = neg ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

// File: hdl/pmu_norm.sv
`default_nettype none
module pmu_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pmu_pkg::t_wvec i_dir,
    output logic           o_done,
    output pmu_pkg::t_cvec o_unit
);
    import pmu_pkg::*;

    localparam int MW = WORD_BITS - 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int RW = WORD_BITS + 2;

    typedef enum logic [5:0] {
        N_IDLE = 6'b000001,
        N_MAG  = 6'b000010,
        N_SQ   = 6'b000100,
        N_ROOT = 6'b001000,
        N_DIV  = 6'b010000,
        N_DONE = 6'b100000
    } t_nstate;

    t_nstate              r_state;
    logic [WORD_BITS-1:0] r_mag [0:2];
    logic                 r_neg [0:2];
    logic [MW-1:0]        r_m [0:2];
    logic [1:0]           r_k;
    logic [4:0]           r_cnt;
    logic [SQ_BITS-1:0]   r_sum;
    logic [SQ_BITS-1:0]   r_n;
    logic [SQ_BITS-1:0]   r_res;
    logic [SQ_BITS-1:0]   r_bit;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_q;
    t_coef                r_unit [0:2];

    logic [WORD_BITS-1:0] mx;
    logic [1:0]           sh;
    logic [SQ_BITS-1:0]   root_t;
    logic                 root_ge;
    logic [WORD_BITS-1:0] len;
    logic                 div_ge;
    logic [RW-1:0]        rem_sub;
    logic [QW-1:0]        n_q;
    logic [2*MW-1:0]      sq;

    // largest magnitude and the shared shift that brings it below 2^30
    always_comb begin
        mx = r_mag[0];
        if (r_mag[1] > mx) mx = r_mag[1];
        if (r_mag[2] > mx) mx = r_mag[2];
        if (mx[WORD_BITS-1]) begin
            sh = 2'd2;
        end else if (mx[WORD_BITS-2]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
    end

    // one root digit and one quotient bit per cycle
    always_comb begin
        sq      = r_m[r_k] * r_m[r_k];
        root_t  = r_res + r_bit;
        root_ge = (r_n >= root_t);
        len     = (r_res == '0) ? WORD_BITS'(1) : r_res[WORD_BITS-1:0];
        div_ge  = (r_rem >= {2'b00, len});
        rem_sub = div_ge ? (r_rem - {2'b00, len}) : r_rem;
        n_q     = {r_q[QW-2:0], div_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_dir[i][WORD_BITS-1];
                            r_mag[i] <= i_dir[i][WORD_BITS-1] ? (~i_dir[i] + 1'b1) : i_dir[i];
                        end
                        r_state <= N_MAG;
                    end
                end
                N_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= MW'(r_mag[i] >> sh);
                    end
                    r_k   <= 2'd0;
                    r_sum <= '0;
                    if (mx == '0) begin
                        for (int i = 0; i < 3; i++) r_unit[i] <= '0;
                        r_state <= N_DONE;
                    end else begin
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_k == 2'd2) begin
                        r_n     <= r_sum + SQ_BITS'(sq);
                        r_res   <= '0;
                        r_bit   <= {2'b01, {(SQ_BITS-2){1'b0}}};
                        r_state <= N_ROOT;
                    end else begin
                        r_sum <= r_sum + SQ_BITS'(sq);
                        r_k   <= r_k + 2'd1;
                    end
                end
                N_ROOT: begin
                    if (root_ge) begin
                        r_n   <= r_n - root_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == SQ_BITS'(1)) begin
                        r_k     <= 2'd0;
                        r_cnt   <= '0;
                        r_q     <= '0;
                        r_rem   <= RW'(r_m[0]);
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    if (r_cnt == 5'(QW - 1)) begin
                        // last quotient bit: store the signed component
                        r_unit[r_k] <= r_neg[r_k] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
                        r_cnt <= '0;
                        r_q   <= '0;
                        if (r_k == 2'd2) begin
                            r_state <= N_DONE;
                        end else begin
                            r_k   <= r_k + 2'd1;
                            r_rem <= RW'(r_m[r_k + 2'd1]);
                        end
                    end else begin
                        r_q   <= n_q;
                        r_rem <= rem_sub << 1;
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == N_DONE);
    assign o_unit = r_unit;

`ifndef ASSERT_OFF
    // a finished unit vector never exceeds one in any component
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(r_unit[0]) <= $signed(ONE_Q[COEF_BITS-1:0]) &&
                    $signed(r_unit[1]) <= $signed(ONE_Q[COEF_BITS-1:0]) &&
                    $signed(r_unit[2]) <= $signed(ONE_Q[COEF_BITS-1:0])))
        else $error("unit component above one");
    // a start is only taken from idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == N_IDLE && i_start) |=> (r_state == N_MAG))
        else $error("normalizer missed a start");
`endif
endmodule
`default_nettype wire

// File: hdl/particle_motion_update_unit.sv
`default_nettype none
// Spawn and dead-tick words go from idle straight to the result, a kill tick through
//   the check state; a live tick runs the step program of the shared multiply-add
//   unit (multiply and add state per active step, multiply state per skipped step),
//   and with attraction the normalizer's 32-step root and 3 x 17-step divider.
// Throughput: one word at a time; the next word is taken once the result is
//   in the output register. Synchronous active-low reset restores state.
module particle_motion_update_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmu_in_if.sink            in_ch,
    pmu_out_if.source         out_ch,
    input  logic              i_cfg_we,
    input  pmu_pkg::t_cfg_idx i_cfg_index,
    input  pmu_pkg::t_word    i_cfg_data
);
    import pmu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_MUL   = 6'b000100,
        S_ADD   = 6'b001000,
        S_NORM  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // step program of the multiply-add unit
    localparam logic [4:0] ST_LOC  = 5'd0;
    localparam logic [4:0] ST_DAMP = 5'd3;
    localparam logic [4:0] ST_DIR  = 5'd6;
    localparam logic [4:0] ST_STR  = 5'd9;
    localparam logic [4:0] ST_ACC  = 5'd10;
    localparam logic [4:0] ST_PULL = 5'd11;
    localparam logic [4:0] ST_COL  = 5'd14;
    localparam logic [4:0] ST_SIZE = 5'd17;
    localparam logic [4:0] ST_LAST = 5'd17;

    t_state r_state;
    logic [4:0] r_step;

    // configuration
    logic [WORD_BITS-2:0] r_lifetime;
    logic  r_damp;
    logic  r_attr;
    t_word r_strength;
    t_word r_cdelta [0:2];
    t_word r_size_delta;

    // particle state
    logic [WORD_BITS-1:0] r_age;
    logic  r_dead;
    t_word r_loc [0:2];
    t_word r_vel [0:2];
    t_word r_col [0:2];
    t_word r_size;
    t_word r_pv [0:2];
    t_wvec r_dir;
    t_word r_s;
    t_word r_acc;
    logic [DT_BITS-1:0] r_dt;

    // output register
    logic  r_o_valid;
    logic  r_o_alive;
    t_word r_o_pos [0:2];
    t_word r_o_col [0:2];
    t_word r_o_size;

    logic  accept;
    logic  mul_en;
    logic  norm_start;
    logic  norm_done;
    t_cvec unit;
    t_prod prod;
    t_coef dt_coef;
    logic [WORD_BITS:0] age_sum;

    // decoded step
    logic [1:0] idx;
    logic       skip;
    t_word      op_a;
    t_coef      op_b;
    t_word      op_x;
    t_prod      op_y;
    logic       op_sub;
    t_word      res;

    assign accept  = in_ch.valid && in_ch.ready;
    assign dt_coef = t_coef'({{(COEF_BITS-DT_BITS){1'b0}}, r_dt});
    assign age_sum = {1'b0, r_age} + (WORD_BITS+1)'(r_dt);

    // operand selection for the current step
    always_comb begin
        idx    = 2'd0;
        skip   = 1'b0;
        op_a   = r_vel[0];
        op_b   = dt_coef;
        op_x   = '0;
        op_y   = prod;
        op_sub = 1'b0;
        if (r_step < ST_DAMP) begin
            idx  = 2'(r_step - ST_LOC);
            op_a = r_vel[idx];
            op_x = r_loc[idx];
        end else if (r_step < ST_DIR) begin
            idx    = 2'(r_step - ST_DAMP);
            skip   = !r_damp;
            op_a   = r_vel[idx];
            op_x   = r_vel[idx];
            op_sub = 1'b1;
        end else if (r_step < ST_STR) begin
            idx    = 2'(r_step - ST_DIR);
            skip   = !r_attr;
            op_x   = r_pv[idx];
            op_y   = {r_loc[idx][WORD_BITS-1], r_loc[idx]};
            op_sub = 1'b1;
        end else if (r_step == ST_STR) begin
            skip   = !(r_attr && r_damp);
            op_a   = r_s;
            op_x   = r_s;
            op_sub = 1'b1;
        end else if (r_step == ST_ACC) begin
            skip = !r_attr;
            op_a = r_s;
        end else if (r_step < ST_COL) begin
            idx  = 2'(r_step - ST_PULL);
            skip = !r_attr;
            op_a = r_acc;
            op_b = unit[idx];
            op_x = r_vel[idx];
        end else if (r_step < ST_SIZE) begin
            idx  = 2'(r_step - ST_COL);
            op_a = r_cdelta[idx];
            op_x = r_col[idx];
        end else begin
            op_a = r_size_delta;
            op_x = r_size;
        end
        res = sat_sum(op_x, op_y, op_sub);
    end

    assign mul_en     = (r_state == S_MUL) && !skip;
    assign norm_start = (r_state == S_ADD) && (r_step == ST_ACC);

    pmu_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod)
    );

    pmu_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_dir   (r_dir),
        .o_done  (norm_done),
        .o_unit  (unit)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime   <= LIFETIME_RESET;
            r_damp       <= 1'b0;
            r_attr       <= 1'b0;
            r_strength   <= '0;
            r_cdelta[0]  <= '0;
            r_cdelta[1]  <= '0;
            r_cdelta[2]  <= '0;
            r_size_delta <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIFETIME:   r_lifetime   <= i_cfg_data[WORD_BITS-2:0];
                CFG_STOP_DAMP:  r_damp       <= i_cfg_data[0];
                CFG_ATTR_EN:    r_attr       <= i_cfg_data[0];
                CFG_ATTR_STR:   r_strength   <= i_cfg_data;
                CFG_COLOR_R:    r_cdelta[0]  <= i_cfg_data;
                CFG_COLOR_G:    r_cdelta[1]  <= i_cfg_data;
                CFG_COLOR_B:    r_cdelta[2]  <= i_cfg_data;
                CFG_SIZE_DELTA: r_size_delta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_o_valid <= 1'b0;
            r_age     <= '0;
            r_dead    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_loc[i] <= '0;
                r_vel[i] <= '0;
            end
            r_col[0] <= ONE_Q;
            r_col[1] <= '0;
            r_col[2] <= '0;
            r_size   <= ONE_Q;
        end else begin
            // result register: load a finished word, or empty it once taken
            if (r_state == S_DONE && (!r_o_valid || out_ch.ready)) begin
                r_o_valid <= 1'b1;
            end else if (out_ch.valid && out_ch.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pv[0] <= in_ch.vec_x;
                        r_pv[1] <= in_ch.vec_y;
                        r_pv[2] <= in_ch.vec_z;
                        r_dt    <= in_ch.time_delta;
                        if (in_ch.mode == MODE_SPAWN) begin
                            r_loc[0] <= in_ch.vec_x;
                            r_loc[1] <= in_ch.vec_y;
                            r_loc[2] <= in_ch.vec_z;
                            r_vel[0] <= in_ch.init_vel_x;
                            r_vel[1] <= in_ch.init_vel_y;
                            r_vel[2] <= in_ch.init_vel_z;
                            r_age    <= '0;
                            r_dead   <= 1'b0;
                            r_size   <= ONE_Q;
                            r_col[0] <= ONE_Q;
                            r_col[1] <= '0;
                            r_col[2] <= '0;
                            r_state  <= S_DONE;
                        end else if (r_dead) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    // lifetime reached: die and hold everything else
                    if (age_sum >= (WORD_BITS+1)'(r_lifetime)) begin
                        r_dead  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_age   <= age_sum[WORD_BITS-1:0];
                        r_s     <= r_strength;
                        r_step  <= ST_LOC;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (skip) begin
                        if (r_step == ST_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (r_step < ST_DAMP) begin
                        r_loc[idx] <= res;
                    end else if (r_step < ST_DIR) begin
                        r_vel[idx] <= res;
                    end else if (r_step < ST_STR) begin
                        r_dir[idx] <= res;
                    end else if (r_step == ST_STR) begin
                        r_s <= res;
                    end else if (r_step == ST_ACC) begin
                        r_acc <= res;
                    end else if (r_step < ST_COL) begin
                        r_vel[idx] <= res;
                    end else if (r_step < ST_SIZE) begin
                        r_col[idx] <= res;
                    end else begin
                        r_size <= res;
                    end
                    if (r_step == ST_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= (r_step == ST_ACC) ? S_NORM : S_MUL;
                    end
                end
                S_NORM: begin
                    if (norm_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || out_ch.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_o_valid || out_ch.ready)) begin
            r_o_alive <= !r_dead;
            r_o_pos   <= r_loc;
            r_o_col   <= r_col;
            r_o_size  <= r_size;
        end
    end

    assign in_ch.ready          = (r_state == S_IDLE);
    assign out_ch.valid         = r_o_valid;
    assign out_ch.alive         = r_o_alive;
    assign out_ch.pos_x         = r_o_pos[0];
    assign out_ch.pos_y         = r_o_pos[1];
    assign out_ch.pos_z         = r_o_pos[2];
    assign out_ch.red           = r_o_col[0];
    assign out_ch.green         = r_o_col[1];
    assign out_ch.blue          = r_o_col[2];
    assign out_ch.particle_size = r_o_size;

`ifndef ASSERT_OFF
    // a taken word closes the input until its result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !in_ch.ready)
        else $error("input open while busy");
    // the step counter stays inside the program
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= ST_LAST)
        else $error("step counter past program end");
    // normalizer only runs when attraction is on
    a_norm_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_start |-> r_attr)
        else $error("normalizer started without attraction");
`endif
endmodule
`default_nettype wire

// File: sim/tb_particle_motion_update_unit.sv
`timescale 1ns / 1ps
module tb_particle_motion_update_unit;
    import pmu_pkg::*;

    localparam longint WMAX_L = 64'sd2147483647;
    localparam longint WMIN_L = -64'sd2147483648;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic   alive;
        longint pos [0:2];
        longint col [0:2];
        longint size_q;
    } t_particle_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_index;
    t_word i_cfg_data;

    pmu_in_if  in_ch ();
    pmu_out_if out_ch ();

    particle_motion_update_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow configuration
    longint unsigned life_q;
    bit damp_on, pull_on;
    longint pull_str, dcol [0:2], dsize;

    // shadow particle state
    longint unsigned age_q;
    bit dead_q;
    longint loc_q [0:2], vel_q [0:2], col_q [0:2], size_q;

    t_particle_out pending_results [$];
    int mismatches;
    int stall_cycles;
    bit idle_on;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat(longint v);
        if (v > WMAX_L) return WMAX_L;
        if (v < WMIN_L) return WMIN_L;
        return v;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // a * b >> 16 truncated toward zero
    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ma, mb, r;
        ma = mag(a);
        mb = mag(b);
        r = (ma >> FRAC_BITS) * mb + (((ma & 64'hFFFF) * mb) >> FRAC_BITS);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // unit direction in Q16.16, zero vector stays zero
    task automatic unit_dir(input longint d [0:2], output longint u [0:2]);
        longint unsigned m [0:2];
        longint unsigned mx, sum, len;
        int sh;
        mx = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(d[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
        end else begin
            while ((mx >> sh) >= (64'd1 << 30)) sh++;
            for (int i = 0; i < 3; i++) begin
                m[i] >>= sh;
                sum += m[i] * m[i];
            end
            len = root_floor(sum);
            if (len == 0) len = 1;
            for (int i = 0; i < 3; i++) begin
                u[i] = longint'((m[i] << FRAC_BITS) / len);
                if (d[i] < 0) u[i] = -u[i];
            end
        end
    endtask

    // advance the shadow particle by one word and queue the expected result
    task automatic advance_particle(input logic mode, input int unsigned dt_raw,
                                    input longint pv [0:2], input longint iv [0:2]);
        t_particle_out r;
        longint dt, s, acc;
        longint dir [0:2], u [0:2];
        if (mode == MODE_SPAWN) begin
            for (int i = 0; i < 3; i++) begin
                loc_q[i] = pv[i];
                vel_q[i] = iv[i];
            end
            age_q = 0;
            dead_q = 0;
            size_q = ONE_Q;
            col_q[0] = ONE_Q;
            col_q[1] = 0;
            col_q[2] = 0;
        end else if (!dead_q) begin
            dt = dt_raw;
            if (age_q + dt >= life_q) begin
                dead_q = 1;
            end else begin
                age_q += dt;
                for (int i = 0; i < 3; i++) loc_q[i] = sat(loc_q[i] + fx_mul(vel_q[i], dt));
                if (damp_on)
                    for (int i = 0; i < 3; i++) vel_q[i] = sat(vel_q[i] - fx_mul(vel_q[i], dt));
                if (pull_on) begin
                    s = pull_str;
                    for (int i = 0; i < 3; i++) dir[i] = sat(pv[i] - loc_q[i]);
                    if (damp_on) s = sat(s - fx_mul(s, dt));
                    unit_dir(dir, u);
                    acc = fx_mul(s, dt);
                    for (int i = 0; i < 3; i++) vel_q[i] = sat(vel_q[i] + fx_mul(acc, u[i]));
                end
                for (int i = 0; i < 3; i++) col_q[i] = sat(col_q[i] + fx_mul(dcol[i], dt));
                size_q = sat(size_q + fx_mul(dsize, dt));
            end
        end
        r.alive = !dead_q;
        r.pos = loc_q;
        r.col = col_q;
        r.size_q = size_q;
        pending_results.push_back(r);
    endtask

    task automatic reset_shadow();
        life_q = 65536;
        damp_on = 0;
        pull_on = 0;
        pull_str = 0;
        dsize = 0;
        age_q = 0;
        dead_q = 0;
        for (int i = 0; i < 3; i++) begin
            dcol[i] = 0;
            loc_q[i] = 0;
            vel_q[i] = 0;
            col_q[i] = 0;
        end
        col_q[0] = ONE_Q;
        size_q = ONE_Q;
    endtask

    // register write, called at a falling edge while the block is idle
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_LIFETIME:   life_q = val & 32'h7FFF_FFFF;
            CFG_STOP_DAMP:  damp_on = val[0];
            CFG_ATTR_EN:    pull_on = val[0];
            CFG_ATTR_STR:   pull_str = longint'($signed(val));
            CFG_COLOR_R:    dcol[0] = longint'($signed(val));
            CFG_COLOR_G:    dcol[1] = longint'($signed(val));
            CFG_COLOR_B:    dcol[2] = longint'($signed(val));
            CFG_SIZE_DELTA: dsize = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] life, input bit damp, input bit pull,
                             input logic [31:0] str, input logic [31:0] cr,
                             input logic [31:0] cg, input logic [31:0] cb,
                             input logic [31:0] sz);
        drain();
        write_reg(CFG_LIFETIME, life);
        write_reg(CFG_STOP_DAMP, {31'd0, damp});
        write_reg(CFG_ATTR_EN, {31'd0, pull});
        write_reg(CFG_ATTR_STR, str);
        write_reg(CFG_COLOR_R, cr);
        write_reg(CFG_COLOR_G, cg);
        write_reg(CFG_COLOR_B, cb);
        write_reg(CFG_SIZE_DELTA, sz);
    endtask

    // send one word; entered and left at a falling edge
    task automatic send_word(input logic mode, input logic [15:0] dt,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz);
        longint pv [0:2], iv [0:2];
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.mode = mode;
        in_ch.time_delta = dt;
        in_ch.vec_x = px;
        in_ch.vec_y = py;
        in_ch.vec_z = pz;
        in_ch.init_vel_x = vx;
        in_ch.init_vel_y = vy;
        in_ch.init_vel_z = vz;
        do @(posedge i_clk); while (!in_ch.ready);
        pv[0] = longint'($signed(px));
        pv[1] = longint'($signed(py));
        pv[2] = longint'($signed(pz));
        iv[0] = longint'($signed(vx));
        iv[1] = longint'($signed(vy));
        iv[2] = longint'($signed(vz));
        advance_particle(mode, dt, pv, iv);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 2 * 65536 * 64) - 65536 * 64;
            4: return $urandom_range(0, 65536 * 4) - 65536 * 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rnd_dt();
        case ($urandom_range(0, 3))
            0: return 16'hFFFF;
            1: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rnd_life();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 65536 * $urandom_range(1, 12);
            2: return $urandom_range(0, 200000);
            default: return $urandom & 32'h7FFF_FFFF;
        endcase
    endfunction

    // compare one field, report the first few mismatches
    task automatic check_field(input string fname, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d at %0t", fname, exp_v, act_v,
                         $realtime);
        end
    endtask

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        t_particle_out e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                e = pending_results.pop_front();
                check_field("alive", e.alive, out_ch.alive);
                check_field("pos_x", sat(e.pos[0]) & 64'hFFFFFFFF, out_ch.pos_x & 64'hFFFFFFFF);
                check_field("pos_y", e.pos[1] & 64'hFFFFFFFF, out_ch.pos_y & 64'hFFFFFFFF);
                check_field("pos_z", e.pos[2] & 64'hFFFFFFFF, out_ch.pos_z & 64'hFFFFFFFF);
                check_field("red", e.col[0] & 64'hFFFFFFFF, out_ch.red & 64'hFFFFFFFF);
                check_field("green", e.col[1] & 64'hFFFFFFFF, out_ch.green & 64'hFFFFFFFF);
                check_field("blue", e.col[2] & 64'hFFFFFFFF, out_ch.blue & 64'hFFFFFFFF);
                check_field("particle_size", e.size_q & 64'hFFFFFFFF,
                            out_ch.particle_size & 64'hFFFFFFFF);
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 2) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(negedge i_clk);
            end
        end
    end

    // field extremes, kill, dead tick, zero direction, zero lifetime
    task automatic test_directed();
        send_word(MODE_TICK, 16'd100, 0, 0, 0, 0, 0, 0);
        send_word(MODE_SPAWN, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(MODE_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        send_word(MODE_TICK, 16'd1, 0, 0, 0, 0, 0, 0);
        send_word(MODE_TICK, 16'd5, 0, 0, 0, 0, 0, 0);
        send_word(MODE_SPAWN, 16'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(MODE_TICK, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_all(32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0001_0000, 32'h8000_0000);
        send_word(MODE_SPAWN, 16'd0, 0, 0, 0, 0, 0, 0);
        send_word(MODE_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        send_word(MODE_TICK, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        send_word(MODE_TICK, 16'h1234, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_word(MODE_SPAWN, 16'd0, 32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0001_8000,
                  32'h0, 32'hFFFF_0000);
        send_word(MODE_TICK, 16'h4000, 32'h0, 32'h0, 32'h0004_0000, 0, 0, 0);
        write_all(32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFF_0000, 32'h7FFF_FFFF);
        send_word(MODE_TICK, 16'hFFFF, 32'h0010_0000, 32'h8000_0000, 32'h0, 0, 0, 0);
        send_word(MODE_TICK, 16'h0001, 32'h0, 32'h0, 32'h0, 0, 0, 0);
        write_all(32'h0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(MODE_SPAWN, 16'd7, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6);
        send_word(MODE_TICK, 16'd0, 0, 0, 0, 0, 0, 0);
        send_word(MODE_TICK, 16'd9, 0, 0, 0, 0, 0, 0);
    endtask

    // spawn then a run of ticks toward a parent, with some stray ticks
    task automatic test_random_motion(input int n_words, input bit hold_off);
        int sent;
        logic [31:0] px, py, pz;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(MODE_TICK, rnd_dt(), rnd_word(), rnd_word(), rnd_word(),
                          rnd_word(), rnd_word(), rnd_word());
                sent++;
            end else begin
                send_word(MODE_SPAWN, rnd_dt(), rnd_word(), rnd_word(), rnd_word(),
                          rnd_word(), rnd_word(), rnd_word());
                px = rnd_word();
                py = rnd_word();
                pz = rnd_word();
                sent++;
                repeat ($urandom_range(1, 15)) begin
                    send_word(MODE_TICK, rnd_dt(), px, py, pz, rnd_word(), rnd_word(),
                              rnd_word());
                    sent++;
                end
            end
            if (hold_off && sent >= n_words / 2 && sent < n_words / 2 + 20) drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LIFETIME;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_SPAWN;
        in_ch.time_delta = '0;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        in_ch.init_vel_x = '0;
        in_ch.init_vel_y = '0;
        in_ch.init_vel_z = '0;
        mismatches = 0;
        stall_cycles = 0;
        idle_on = 1;
        reset_shadow();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) idle_on = 0;
            write_all(rnd_life(), $urandom_range(0, 1), (ph % 3) != 0, rnd_word(), rnd_word(),
                      rnd_word(), rnd_word(), rnd_word());
            test_random_motion(300, ph == 2);
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/pmu_pkg.sv
hdl/pmu_in_if.sv
hdl/pmu_out_if.sv
hdl/pmu_mul.sv
hdl/pmu_norm.sv
hdl/particle_motion_update_unit.sv
sim/tb_particle_motion_update_unit.sv
